### sv/alx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_pkg: shared types and constants of the lux calculator
// Field widths, region codes, fixed-point formula coefficients and the
// ratio^1.4 table generator.
// ----------------------------------------------------------------------------
package alx_pkg;

	localparam int CNT_W   = 16;
	localparam int SCALE_W = 16;
	localparam int LUX_W   = 32;
	localparam int NUM_W   = 35;   // width of raw lux in Q11.24 after the 2^16 drop

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	typedef enum logic [2:0] {
		RGN_ZERO = 3'd0,
		RGN_1    = 3'd1,
		RGN_2    = 3'd2,
		RGN_3    = 3'd3,
		RGN_4    = 3'd4,
		RGN_OOR  = 3'd5
	} region_t;

	// ratio borders in hundredths
	localparam logic [22:0] K_R1  = 23'd50;
	localparam logic [22:0] K_R2  = 23'd61;
	localparam logic [22:0] K_R3  = 23'd80;
	localparam logic [22:0] K_R4  = 23'd130;
	localparam logic [22:0] K_100 = 23'd100;

	// coefficients, round(c * 2^24)
	localparam logic [18:0] C_R1_A = 19'd510027;
	localparam logic [19:0] C_R1_B = 20'd1040187;
	localparam logic [18:0] C_R2_A = 19'd375810;
	localparam logic [19:0] C_R2_B = 20'd520094;
	localparam logic [18:0] C_R3_A = 19'd214748;
	localparam logic [19:0] C_R3_B = 20'd256691;
	localparam logic [18:0] C_R4_A = 19'd24495;
	localparam logic [19:0] C_R4_B = 20'd18790;

	typedef struct packed {
		logic [CNT_W-1:0] bb;
		logic [CNT_W-1:0] ir;
		region_t          region;
	} item_t;

	// floor((i/d)^1.4 * 2^16): largest t with t^5 * d^7 <= i^7 * 2^80
	function automatic logic [31:0] pow_entry(input int unsigned i, input int unsigned d);
		logic [191:0] rhs;
		logic [191:0] lhs;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		int           k;
		rhs = 192'd1;
		for (k = 0; k < 7; k++) rhs = rhs * 192'(i);
		rhs = rhs << 80;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = lo + ((hi - lo + 1) >> 1);
			lhs = 192'd1;
			for (k = 0; k < 5; k++) lhs = lhs * 192'(mid);
			for (k = 0; k < 7; k++) lhs = lhs * 192'(d);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return 32'(lo);
	endfunction

endpackage

### sv/alx_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_in_if: sample channel
// Valid/ready channel carrying one broadband/infrared count pair per beat.
// ----------------------------------------------------------------------------
interface alx_in_if import alx_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] broadband_count;
	logic [CNT_W-1:0] infrared_count;

	modport source(output valid, broadband_count, infrared_count, input ready);
	modport sink(input valid, broadband_count, infrared_count, output ready);
endinterface

### sv/alx_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_out_if: result channel
// Valid/ready channel carrying one lux result per beat.
// ----------------------------------------------------------------------------
interface alx_out_if import alx_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LUX_W-1:0] lux_q16_16;
	logic [2:0]       region_code;
	logic             saturated;

	modport source(output valid, lux_q16_16, region_code, saturated, input ready);
	modport sink(input valid, lux_q16_16, region_code, saturated, output ready);
endinterface

### sv/alx_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_div_pipe: pipelined restoring divider
// One quotient bit per stage; divisor and side data travel with the item.
// ----------------------------------------------------------------------------
module alx_div_pipe #(
	parameter int QW  = 16,
	parameter int DW  = 16,
	parameter int SBW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [DW-1:0]  in_rem,
	input  logic [QW-1:0]  in_num,
	input  logic [DW-1:0]  in_den,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	output logic [QW-1:0]  out_quo,
	output logic [SBW-1:0] out_sb
);

	logic           vld_s [QW];
	logic [DW-1:0]  rem_s [QW];
	logic [QW-1:0]  num_s [QW];
	logic [DW-1:0]  den_s [QW];
	logic [SBW-1:0] sb_s  [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic           src_vld;
		logic [DW-1:0]  src_rem;
		logic [QW-1:0]  src_num;
		logic [DW-1:0]  src_den;
		logic [SBW-1:0] src_sb;
		logic [DW:0]    trial;
		logic           ge;

		if (g == 0) begin : g_src
			assign src_vld = in_valid;
			assign src_rem = in_rem;
			assign src_num = in_num;
			assign src_den = in_den;
			assign src_sb  = in_sb;
		end else begin : g_src
			assign src_vld = vld_s[g-1];
			assign src_rem = rem_s[g-1];
			assign src_num = num_s[g-1];
			assign src_den = den_s[g-1];
			assign src_sb  = sb_s[g-1];
		end

		// shift in next dividend bit, subtract when it fits
		assign trial = {src_rem, src_num[QW-1]};
		assign ge    = (trial >= {1'b0, src_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? DW'(trial - {1'b0, src_den}) : trial[DW-1:0];
				num_s[g] <= {src_num[QW-2:0], ge};
				den_s[g] <= src_den;
				sb_s[g]  <= src_sb;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quo   = num_s[QW-1];
	assign out_sb    = sb_s[QW-1];

endmodule

### sv/alx_pow_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_pow_interp: ratio^1.4 lookup with linear interpolation
// Three stages: table position, table read, interpolation.
// ----------------------------------------------------------------------------
module alx_pow_interp import alx_pkg::*; #(
	parameter int N   = 64,
	parameter int F   = 16,
	parameter int SBW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [F-1:0]   in_ratio,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	output logic [15:0]    out_pow,
	output logic [SBW-1:0] out_sb
);

	localparam int PMUL = 2 * (N - 1);
	localparam int PW   = F + $clog2(2 * N);
	localparam int IW   = PW - F;
	localparam int TW   = $clog2(N);

	logic [15:0] pow_tab [N];

	for (genvar g = 0; g < N; g++) begin : g_tab
		assign pow_tab[g] = 16'(pow_entry(g, PMUL));
	end

	logic           vld_s1, vld_s2, vld_s3;
	logic [PW-1:0]  pos_s1;
	logic [15:0]    ta_s2, tb_s2;
	logic [F-1:0]   frac_s2;
	logic [15:0]    pow_s3;
	logic [SBW-1:0] sb_s1, sb_s2, sb_s3;

	logic [IW-1:0]  idx;
	logic [TW-1:0]  tidx;
	logic           last;
	logic [F+15:0]  step;

	assign idx  = pos_s1[PW-1:F];
	assign tidx = idx[TW-1:0];
	assign last = (idx >= IW'(N - 1));
	assign step = (F+16)'(tb_s2 - ta_s2) * (F+16)'(frac_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1  <= PW'(in_ratio) * PW'(PMUL);
			sb_s1   <= in_sb;
			// clamp at the last sample
			ta_s2   <= last ? pow_tab[N-1] : pow_tab[tidx];
			tb_s2   <= last ? pow_tab[N-1] : pow_tab[TW'(tidx + 1'b1)];
			frac_s2 <= pos_s1[F-1:0];
			sb_s2   <= sb_s1;
			pow_s3  <= ta_s2 + 16'(step >> F);
			sb_s3   <= sb_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_pow   = pow_s3;
	assign out_sb    = sb_s3;

endmodule

### sv/ambient_light_lux_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_lux_calc: two-channel ambient light lux calculator
// Piecewise lux formula on broadband/infrared counts, scaled and saturated.
// ----------------------------------------------------------------------------
// Usage:
//  - sample (valid/ready): one broadband and one infrared count per beat.
//  - result (valid/ready): one beat per sample, in order: lux in unsigned
//    Q16.16, region code (0 zero broadband count, 1..4 formula, 5 ratio above 1.30)
//    and a saturation flag.
//  - cfg_wr_en/cfg_wr_data: write the Q8.8 integration/gain divisor. Write
//    only while no sample is in flight. Zero acts as the smallest step.
//  - Throughput: one sample per cycle while the result is not stalled. The
//    pipeline holds two bit-per-stage dividers: the ratio divider
//    (RATIO_FRAC_BITS stages) and the lux divider (35 stages).
//  - A stalled result holds the whole pipeline in place: sample.ready drops
//    until the result beat is taken; no beat is lost or repeated.
//  - Reset clears all stage valid bits and loads the divisor with 1.0.
// ----------------------------------------------------------------------------
module ambient_light_lux_calc import alx_pkg::*; #(
	parameter int POW_TABLE_ENTRIES = 64,
	parameter int RATIO_FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	alx_in_if.sink             sample,
	alx_out_if.source          result,
	input  logic               cfg_wr_en,
	input  logic [SCALE_W-1:0] cfg_wr_data
);

	localparam int F   = RATIO_FRAC_BITS;
	localparam int IBW = $bits(item_t);

	// divisor register
	logic [SCALE_W-1:0] scale_q;
	logic [SCALE_W-1:0] scale_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	assign scale_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;

	// whole pipeline advances unless the output beat is stuck
	logic adv;
	logic vld_s8;

	assign adv          = !vld_s8 || result.ready;
	assign sample.ready = adv;

	// ---------------- stage 1: region select ----------------
	// 24 bits hold bb * 130 at full scale
	logic [23:0] ir100, bb24;
	region_t     region_c;
	logic        vld_s1;
	item_t       item_s1;

	assign ir100 = 24'(sample.infrared_count) * K_100;
	assign bb24  = 24'(sample.broadband_count);

	always_comb begin
		if (sample.broadband_count == '0) region_c = RGN_ZERO;
		else if (ir100 <= bb24 * K_R1) region_c = RGN_1;
		else if (ir100 <= bb24 * K_R2) region_c = RGN_2;
		else if (ir100 <= bb24 * K_R3) region_c = RGN_3;
		else if (ir100 <= bb24 * K_R4) region_c = RGN_4;
		else region_c = RGN_OOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.bb     <= sample.broadband_count;
			item_s1.ir     <= sample.infrared_count;
			item_s1.region <= region_c;
		end
	end

	// ---------------- ratio = ir * 2^F / bb ----------------
	// Only used in region 1, where ir <= bb/2, so the quotient fits F bits
	// and the starting remainder ir is already below bb.
	logic             vld_rd;
	logic [F-1:0]     ratio_rd;
	logic [IBW-1:0]   sb_rd;

	alx_div_pipe #(.QW(F), .DW(CNT_W), .SBW(IBW)) u_ratio_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (vld_s1),
		.in_rem   (item_s1.ir),
		.in_num   ('0),
		.in_den   (item_s1.bb),
		.in_sb    (IBW'(item_s1)),
		.out_valid(vld_rd),
		.out_quo  (ratio_rd),
		.out_sb   (sb_rd)
	);

	// ---------------- ratio^1.4 ----------------
	logic           vld_pw;
	logic [15:0]    pow_pw;
	logic [IBW-1:0] sb_pw;
	item_t          item_pw;

	alx_pow_interp #(.N(POW_TABLE_ENTRIES), .F(F), .SBW(IBW)) u_pow (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (vld_rd),
		.in_ratio (ratio_rd),
		.in_sb    (sb_rd),
		.out_valid(vld_pw),
		.out_pow  (pow_pw),
		.out_sb   (sb_pw)
	);

	assign item_pw = item_t'(sb_pw);

	// ---------------- stage 5: products ----------------
	logic [18:0] coef_a;
	logic [19:0] coef_b;

	always_comb begin
		case (item_pw.region)
			RGN_1: begin
				coef_a = C_R1_A;
				coef_b = '0;
			end
			RGN_2: begin
				coef_a = C_R2_A;
				coef_b = C_R2_B;
			end
			RGN_3: begin
				coef_a = C_R3_A;
				coef_b = C_R3_B;
			end
			RGN_4: begin
				coef_a = C_R4_A;
				coef_b = C_R4_B;
			end
			default: begin
				coef_a = '0;
				coef_b = '0;
			end
		endcase
	end

	logic        vld_s5, vld_s6, vld_s7;
	logic [31:0] bbp_s5;
	logic [34:0] cab_s5, cab_s6;
	logic [35:0] cbi_s5, cbi_s6;
	region_t     rgn_s5, rgn_s6, rgn_s7;
	logic [50:0] m_s6;
	logic [NUM_W-1:0]   num_s7;
	logic [SCALE_W-1:0] den_s7;

	// ---------------- stage 7: raw lux / 2^16 ----------------
	// Region 1 loses fraction bits: c0*bb - ceil(c1*bb*p / 2^16) equals the
	// floor of the exact raw lux over 2^16.
	logic [35:0] sub_c;
	logic [36:0] diff_c;
	logic        use_c;

	assign sub_c  = (rgn_s6 == RGN_1) ? 36'((m_s6 + 51'd65535) >> 16) : cbi_s6;
	assign diff_c = 37'(cab_s6) - 37'(sub_c);
	assign use_c  = (rgn_s6 == RGN_1 || rgn_s6 == RGN_2 || rgn_s6 == RGN_3 ||
	                 rgn_s6 == RGN_4) && !diff_c[36];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_pw;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bbp_s5 <= 32'(item_pw.bb) * 32'(pow_pw);
			cab_s5 <= 35'(coef_a) * 35'(item_pw.bb);
			cbi_s5 <= 36'(coef_b) * 36'(item_pw.ir);
			rgn_s5 <= item_pw.region;
			m_s6   <= 51'(C_R1_B) * 51'(bbp_s5);
			cab_s6 <= cab_s5;
			cbi_s6 <= cbi_s5;
			rgn_s6 <= rgn_s5;
			// clamp negative raw lux and non-formula regions to zero
			num_s7 <= use_c ? diff_c[NUM_W-1:0] : '0;
			den_s7 <= scale_eff;
			rgn_s7 <= rgn_s6;
		end
	end

	// ---------------- lux = raw / scale ----------------
	logic               vld_ld;
	logic [NUM_W-1:0]   quo_ld;
	logic [2:0]         sb_ld;

	alx_div_pipe #(.QW(NUM_W), .DW(SCALE_W), .SBW(3)) u_lux_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (vld_s7),
		.in_rem   ('0),
		.in_num   (num_s7),
		.in_den   (den_s7),
		.in_sb    (3'(rgn_s7)),
		.out_valid(vld_ld),
		.out_quo  (quo_ld),
		.out_sb   (sb_ld)
	);

	// ---------------- stage 8: saturate, output beat ----------------
	logic [LUX_W-1:0] lux_s8;
	logic [2:0]       rgn_s8;
	logic             sat_s8;
	logic             over_c;

	assign over_c = (quo_ld[NUM_W-1:LUX_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_ld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lux_s8 <= over_c ? '1 : quo_ld[LUX_W-1:0];
			sat_s8 <= over_c;
			rgn_s8 <= sb_ld;
		end
	end

	assign result.valid       = vld_s8;
	assign result.lux_q16_16  = lux_s8;
	assign result.region_code = rgn_s8;
	assign result.saturated   = sat_s8;

	// ---------------- checks ----------------
	a_nonformula_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && (rgn_s8 == RGN_ZERO || rgn_s8 == RGN_OOR) |-> lux_s8 == '0 && !sat_s8)
		else $error("non-formula region with nonzero lux");

	a_sat_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && sat_s8 |-> lux_s8 == '1)
		else $error("saturated result not at full scale");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && !result.ready |=> $stable(vld_s7) && $stable(num_s7))
		else $error("pipeline moved during output stall");

endmodule
